@@ design/csrspmv_pkg.sv @@
// Shared constants for the CSR sparse matrix-vector multiply unit.
// No dependencies; imported by csr_sparse_matrix_vector_multiply_unit.
package csrspmv_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned ActionW = 2;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned RowNumW = 16;
  localparam int unsigned AccW    = 64;

  // Number of vector entries that the index field can address
  localparam int unsigned IndexSpan = 1 << IndexW;

  // Parameter defaults
  localparam int unsigned VectorDepthDefault   = 4096;
  localparam int unsigned RowCountLimitDefault = 65536;

  // Action codes
  localparam logic [ActionW-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ActionW-1:0] ACT_NONZERO = 2'd1;
  localparam logic [ActionW-1:0] ACT_EMPTY   = 2'd2;

endpackage

@@ design/csr_sparse_matrix_vector_multiply_unit.sv @@
// CSR sparse matrix times dense vector: vector store, multiply-accumulate, row output.
// Depends on csrspmv_pkg (field widths, action codes, parameter defaults).
//
//   channel | dir | handshake                 | fields
//   --------+-----+---------------------------+-------------------------------------------
//   in      | in  | in_valid_i / in_ready_o   | action_i, index_i, value_i, last_in_row_i
//   out     | out | out_valid_o / out_ready_i | row_number_o, row_sum_o, overflowed_o
//
// Steps: a vector load (or an ignored action) is taken in the idle state alone, an empty
//   row goes on to hand-off, a nonzero passes store read, multiply and accumulate, and a
//   nonzero that ends its row adds hand-off. The single-port vector store with its
//   registered read, followed by one 32x32 multiplier and a 64-bit adder, each behind a
//   register, sets these steps; one transaction is in work at a time.
// Reset: control state, the accumulator and the row counter clear asynchronously. The
//   vector store is not cleared; the user must load an entry before it is read; not enforced.
// Stalls: the result sits in an output register, so a new input transaction is taken
//   while a result waits; only a second result waits in the hand-off state until the
//   output register frees up.
module csr_sparse_matrix_vector_multiply_unit
  import csrspmv_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH    = VectorDepthDefault,
  parameter int unsigned ROW_COUNT_LIMIT = RowCountLimitDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [IndexW-1:0]  index_i,
  input  logic [ValueW-1:0]  value_i,
  input  logic               last_in_row_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [RowNumW-1:0] row_number_o,
  output logic [ValueW-1:0]  row_sum_o,
  output logic               overflowed_o
);

  // The index field reaches at most IndexSpan entries, so the store never needs more.
  localparam int unsigned StoreDepth = (VECTOR_DEPTH < IndexSpan) ? VECTOR_DEPTH : IndexSpan;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(ROW_COUNT_LIMIT);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0]        state_q, state_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [CntW-1:0]   row_cnt_q, row_cnt_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers (no reset)
  logic [ValueW-1:0] value_q;
  logic              col_ok_q;
  logic              last_q;
  logic [ValueW-1:0] prod_q;
  logic [ValueW-1:0] emit_sum_q;
  logic              emit_over_q;
  logic [RowNumW-1:0] out_row_q;
  logic [ValueW-1:0] out_sum_q;
  logic              out_over_q;

  // Vector store
  logic [ValueW-1:0] mem_q [StoreDepth];
  logic [ValueW-1:0] rd_data_q;

  logic              in_fire;
  logic              idx_in_range;
  logic              load_fire;
  logic              nz_fire;
  logic              empty_fire;
  logic              emit_fire;
  logic [AccW-1:0]   acc_sum;
  logic [ValueW-1:0] mul_operand;
  logic [ValueW-1:0] mul_low;
  logic [31:0]       cnt_ext;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign idx_in_range = ({20'd0, index_i} < 32'(VECTOR_DEPTH));
  assign load_fire    = in_fire && (action_i == ACT_LOAD) && idx_in_range;
  assign nz_fire      = in_fire && (action_i == ACT_NONZERO);
  assign empty_fire   = in_fire && (action_i == ACT_EMPTY);
  assign emit_fire    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  // Out-of-range column reads as zero. Only the low word of the product is kept.
  assign mul_operand = col_ok_q ? rd_data_q : '0;
  assign mul_low     = value_q * mul_operand;
  assign acc_sum     = acc_q + {32'd0, prod_q};
  assign cnt_ext     = 32'(row_cnt_q);

  // Store: write on a load, registered read on a nonzero. Only one transaction is
  // accepted per edge, so a read never meets a write on the same edge and no same-entry
  // collision needs forwarding.
  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      mem_q[index_i[AddrW-1:0]] <= value_i;
    end
    if (nz_fire) begin
      rd_data_q <= mem_q[index_i[AddrW-1:0]];
    end
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    row_cnt_d   = row_cnt_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (load_fire) begin
          row_cnt_d = '0;
        end else if (nz_fire) begin
          state_d = S_MUL;
        end else if (empty_fire) begin
          state_d = S_EMIT;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (last_q) begin
          acc_d   = '0;
          state_d = S_EMIT;
        end else begin
          acc_d   = acc_sum;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (row_cnt_q == CntW'(ROW_COUNT_LIMIT - 1)) begin
            row_cnt_d = '0;
          end else begin
            row_cnt_d = row_cnt_q + CntW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      row_cnt_q   <= row_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nz_fire) begin
      value_q  <= value_i;
      col_ok_q <= idx_in_range;
      last_q   <= last_in_row_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= mul_low;
    end
    if (empty_fire) begin
      emit_sum_q  <= '0;
      emit_over_q <= 1'b0;
    end else if ((state_q == S_ACC) && last_q) begin
      emit_sum_q  <= acc_sum[ValueW-1:0];
      emit_over_q <= |acc_sum[AccW-1:ValueW];
    end
    if (emit_fire) begin
      out_row_q  <= cnt_ext[RowNumW-1:0];
      out_sum_q  <= emit_sum_q;
      out_over_q <= emit_over_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_number_o = out_row_q;
  assign row_sum_o    = out_sum_q;
  assign overflowed_o = out_over_q;

  // An empty row goes straight to hand-off with a zero sum.
  a_empty_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_fire |=> (state_q == S_EMIT) && (emit_sum_q == '0) && !emit_over_q)
    else $error("empty row did not stage a zero result");

  // An in-range vector load restarts the row count.
  a_load_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire |=> (row_cnt_q == '0))
    else $error("vector load did not clear the row counter");

  // A handed-off row carries the count that was current at hand-off.
  a_emit_row_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_valid_o && (row_number_o == $past(cnt_ext[RowNumW-1:0])))
    else $error("row result has the wrong row number");

  // Closing a row leaves the accumulator cleared for the next one.
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_ACC) && last_q) |=> (acc_q == '0))
    else $error("accumulator not cleared after row end");

endmodule

@@ tb/csr_sparse_matrix_vector_multiply_unit_tb.sv @@
// Self-checking testbench for csr_sparse_matrix_vector_multiply_unit.
// Depends on csrspmv_pkg for widths, action codes and parameter defaults.
// Runs directed CSR rows and a long random mix, with random idling switched on and off.
module csr_sparse_matrix_vector_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csrspmv_pkg::*;

  // Action code 3 has no meaning; the block must drop it without a result
  localparam logic [ActionW-1:0] ACT_SPARE = 2'd3;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;    // slack for a nonzero still in the path
  localparam int unsigned RandomItems = 950;
  localparam int unsigned HoldCycles  = 300;  // long output hold under pressure
  localparam int unsigned BurstItems  = 24;

  typedef struct {
    logic [RowNumW-1:0] row_num;
    logic [ValueW-1:0]  sum;
    logic               over;
  } row_result_t;

  // Tracks the vector store, running row sum and row counter, and keeps
  // the finished rows that the block still owes us, oldest first.
  class row_sum_tracker;
    logic [ValueW-1:0] vec_copy [VectorDepthDefault];
    logic [AccW-1:0]   partial_sum;
    int unsigned       next_row;
    row_result_t       due_rows [$];
    int unsigned       errors;
    int unsigned       rows_seen;
    int unsigned       overflow_rows;

    function new();
      foreach (vec_copy[i]) vec_copy[i] = '0;
      partial_sum   = '0;
      next_row      = 0;
      errors        = 0;
      rows_seen     = 0;
      overflow_rows = 0;
    endfunction

    function void finish_row(logic [ValueW-1:0] sum, logic over);
      row_result_t r;
      r.row_num = next_row[RowNumW-1:0];
      r.sum     = sum;
      r.over    = over;
      due_rows  = {due_rows, r};
      next_row++;
      if (next_row >= RowCountLimitDefault) next_row = 0;
    endfunction

    // Note one accepted input transaction
    function void take_item(logic [ActionW-1:0] act, logic [IndexW-1:0] idx,
                            logic [ValueW-1:0] val, logic last);
      logic [ValueW-1:0] elem;
      logic [ValueW-1:0] prod;
      case (act)
        ACT_LOAD: begin
          // out-of-range loads are dropped and leave the counter alone
          if (idx < VectorDepthDefault) begin
            vec_copy[idx] = val;
            next_row      = 0;
          end
        end
        ACT_NONZERO: begin
          elem = (idx < VectorDepthDefault) ? vec_copy[idx] : '0;
          prod = val * elem;  // product wraps at 32 bits
          partial_sum = partial_sum + AccW'(prod);
          if (last) begin
            finish_row(partial_sum[ValueW-1:0], |partial_sum[AccW-1:ValueW]);
            partial_sum = '0;
          end
        end
        ACT_EMPTY: finish_row('0, 1'b0);  // partial sum stays untouched
        default: ;
      endcase
    endfunction

    // Compare one accepted output transaction with the oldest owed row
    function void check_row(logic [RowNumW-1:0] row, logic [ValueW-1:0] sum, logic over);
      row_result_t e;
      rows_seen++;
      if (over === 1'b1) overflow_rows++;
      if (due_rows.size() == 0) begin
        $error("row result with none owed: row_number %0d row_sum 0x%08h overflowed %b",
               row, sum, over);
        errors++;
        return;
      end
      e = due_rows.pop_front();
      if (row !== e.row_num) begin
        $error("row_number: expected %0d, got %0d", e.row_num, row);
        errors++;
      end
      if (sum !== e.sum) begin
        $error("row_sum: expected 0x%08h, got 0x%08h", e.sum, sum);
        errors++;
      end
      if (over !== e.over) begin
        $error("overflowed: expected %b, got %b", e.over, over);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_rows.size();
    endfunction
  endclass

  // Clock, reset and DUT pins; every signal the bench drives starts at a known value
  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [ActionW-1:0] act_d     = ACT_LOAD;
  logic [IndexW-1:0]  idx_d     = '0;
  logic [ValueW-1:0]  val_d     = '0;
  logic               last_d    = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RowNumW-1:0] row_num;
  logic [ValueW-1:0]  row_sum;
  logic               over;

  row_sum_tracker tracker = new();

  // Shared between the sender (main) and the receiver process
  bit          idle_on      = 1'b1;  // random gaps/stalls enabled
  int unsigned hold_request = 0;     // one-shot long output hold, in cycles
  int unsigned cycle_count  = 0;
  int unsigned items_sent   = 0;

  // Vector entries loaded so far; nonzeros only ever read from these
  bit                loaded      [VectorDepthDefault];
  logic [IndexW-1:0] loaded_list [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  csr_sparse_matrix_vector_multiply_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (act_d),
    .index_i       (idx_d),
    .value_i       (val_d),
    .last_in_row_i (last_d),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .row_number_o  (row_num),
    .row_sum_o     (row_sum),
    .overflowed_o  (over)
  );

  // Hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("csr_sparse_matrix_vector_multiply_unit verification failed");
      $finish;
    end
  end

  // Offer one input transaction after a random gap while idling is on, and wait for its acceptance.
  // Called at a rising edge; valid stays high across back-to-back transactions.
  task automatic send_item(input logic [ActionW-1:0] act, input logic [IndexW-1:0] idx,
                           input logic [ValueW-1:0] val, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    act_d    <= act;
    idx_d    <= idx;
    val_d    <= val;
    last_d   <= last;
    do @(posedge clk); while (!in_ready);
    tracker.take_item(act, idx, val, last);
    if (act == ACT_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list = {loaded_list, idx};
    end
    items_sent++;
  endtask

  // Drop valid and wait until every owed row is back, plus pipeline slack
  // for loads or ignored actions that may still be in flight.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [IndexW-1:0] pick_column();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  // Values skewed toward the corners so overflow and zero sums show up often
  function automatic logic [ValueW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return '1;
      1:       return ValueW'($urandom_range(0, 255));
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: stalls a random number of cycles before each output transaction,
  // or for one long stretch when the sender asks for pressure.
  initial begin
    int unsigned stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_row(row_num, row_sum, over);
    end
  end

  // Sender: directed rows, then random CSR traffic
  initial begin
    int unsigned random_count;
    int unsigned row_len;
    int unsigned pick;
    bit          pressure_done;
    bit          pause_done;
    bit          saved_idle;

    random_count  = 0;
    pressure_done = 1'b0;
    pause_done    = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner vector entries
    send_item(ACT_LOAD, '0, '1, 1'b0);
    send_item(ACT_LOAD, '1, '1, 1'b1);
    send_item(ACT_LOAD, 12'd1, 32'd1, 1'b0);
    send_item(ACT_LOAD, 12'd2, 32'h8000_0000, 1'b0);
    // single-nonzero row; all-ones squared wraps to 1
    send_item(ACT_NONZERO, '1, '1, 1'b1);
    // three products, two of them big: the row sum crosses 32 bits
    send_item(ACT_NONZERO, '0, '1, 1'b0);
    send_item(ACT_NONZERO, 12'd1, '1, 1'b0);
    send_item(ACT_NONZERO, 12'd1, '1, 1'b1);
    // zero value gives a zero row
    send_item(ACT_NONZERO, 12'd2, '0, 1'b1);
    // empty row with every payload bit set; payload is don't-care
    send_item(ACT_EMPTY, '1, '1, 1'b1);
    // empty row in the middle of a row must not disturb the partial sum
    send_item(ACT_NONZERO, 12'd1, 32'd5, 1'b0);
    send_item(ACT_EMPTY, '0, '0, 1'b0);
    send_item(ACT_NONZERO, 12'd1, 32'd7, 1'b1);
    // vector load mid-row: counter restarts, partial sum carries on
    send_item(ACT_NONZERO, 12'd1, 32'd3, 1'b0);
    send_item(ACT_LOAD, 12'd5, 32'h1234_5678, 1'b1);
    send_item(ACT_NONZERO, 12'd5, 32'd2, 1'b1);
    // unused action code, both payload extremes
    send_item(ACT_SPARE, '1, '1, 1'b1);
    send_item(ACT_SPARE, '0, '0, 1'b0);
    send_item(ACT_NONZERO, '0, '0, 1'b1);
    // rewrite an entry and read the new value
    send_item(ACT_LOAD, '1, '0, 1'b0);
    send_item(ACT_NONZERO, '1, '1, 1'b1);
    settle();

    // Random part: mostly well-formed rows over loaded columns, with loads,
    // empty rows and dead actions mixed in, sometimes inside a row.
    repeat (16) send_item(ACT_LOAD, IndexW'($urandom), rand_word(), 1'($urandom));
    random_count = 16;
    while (random_count < RandomItems) begin
      if ($urandom_range(0, 49) == 0) idle_on = !idle_on;

      // Pressure: receiver holds off while we stream short rows back to back
      if (!pressure_done && random_count >= 300) begin
        pressure_done = 1'b1;
        saved_idle    = idle_on;
        idle_on       = 1'b0;
        hold_request  = HoldCycles;
        repeat (BurstItems) send_item(ACT_NONZERO, pick_column(), rand_word(), 1'b1);
        random_count += BurstItems;
        idle_on = saved_idle;
      end

      // Sender pause until the block has handed back everything
      if (!pause_done && random_count >= 600) begin
        pause_done = 1'b1;
        settle();
      end

      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(ACT_LOAD, IndexW'($urandom), rand_word(), 1'($urandom));
        random_count++;
      end else if (pick < 15) begin
        send_item(ACT_EMPTY, IndexW'($urandom), $urandom, 1'($urandom));
        random_count++;
      end else if (pick < 18) begin
        send_item(ACT_SPARE, IndexW'($urandom), $urandom, 1'($urandom));
        random_count++;
      end else begin
        row_len = $urandom_range(1, 6);
        for (int k = 0; k < row_len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            send_item(ACT_LOAD, IndexW'($urandom), rand_word(), 1'($urandom));
            random_count++;
          end else if (pick < 5) begin
            send_item(ACT_EMPTY, IndexW'($urandom), $urandom, 1'($urandom));
            random_count++;
          end else if (pick < 6) begin
            send_item(ACT_SPARE, IndexW'($urandom), $urandom, 1'($urandom));
            random_count++;
          end
          send_item(ACT_NONZERO, pick_column(), rand_word(), k == row_len - 1);
          random_count++;
        end
      end
    end
    settle();

    $display("Checked %0d row results (%0d overflowed) from %0d input transactions.",
             tracker.rows_seen, tracker.overflow_rows, items_sent);
    $display("Mix included mid-row loads and empty rows, dead actions, a long output hold");
    $display("and a full drain pause.");
    if (tracker.errors == 0) begin
      $display("csr_sparse_matrix_vector_multiply_unit verification clean");
    end else begin
      $display("csr_sparse_matrix_vector_multiply_unit verification failed");
    end
    $finish;
  end

endmodule
